// ----- src/tpc_pkg.sv -----
// Package for the three-to-four printable codec: payload structs, group job
// type, register indexes and codec constants. No dependencies.
package tpc_pkg;

  // Character offset added on encode, removed on decode
  localparam logic [7:0] CharOffset = 8'd33;

  // Group jobs that may wait between front and back
  localparam int unsigned JobDepth = 2;

  // Configuration port widths
  localparam int unsigned CfgIdxWidth  = 1;
  localparam int unsigned CfgDataWidth = 16;

  // Register indexes
  localparam logic [CfgIdxWidth-1:0] RegDecodeMode    = 1'd0;
  localparam logic [CfgIdxWidth-1:0] RegMessageLength = 1'd1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  // One finished group: up to four result bytes, index of the last one
  // and whether that last one closes the message.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            ending;
  } job_t;

endpackage

// ----- src/tpc_front.sv -----
// Front part of the codec: holds configuration, gathers items into groups
// and turns each completed group (in encode mode also a short final one) into one job. Depends on tpc_pkg.
module tpc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tpc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tpc_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                accept_i,
  input  tpc_pkg::in_item_t                   item_i,
  output logic                                job_valid_o,
  output tpc_pkg::job_t                       job_o
);
  import tpc_pkg::*;

  logic        decode_q;
  logic [15:0] length_q;
  logic [15:0] remain_q, remain_d;
  logic [23:0] group_q, group_d;
  logic [1:0]  pos_q, pos_d;

  logic [1:0]  enc_pos;
  logic [23:0] enc_grp;
  logic [7:0]  dec_val;
  logic [23:0] dec_grp;
  logic [1:0]  take;
  logic [7:0]  ea, eb, ec;

  // Gather the incoming item into the group
  always_comb begin
    enc_pos = (pos_q == 2'd3) ? 2'd2 : pos_q;
    dec_val = item_i.in_byte - CharOffset;
    case (enc_pos)
      2'd0:    enc_grp = group_q | {item_i.in_byte, 16'h0000};
      2'd1:    enc_grp = group_q | {8'h00, item_i.in_byte, 8'h00};
      default: enc_grp = group_q | {16'h0000, item_i.in_byte};
    endcase
    case (pos_q)
      2'd0:    dec_grp = group_q | {dec_val, 16'h0000};
      2'd1:    dec_grp = group_q | {8'h00, dec_val, 8'h00};
      default: dec_grp = group_q | {16'h0000, dec_val};
    endcase
    take = (remain_q >= 16'd3) ? 2'd3 : remain_q[1:0];
    ea   = group_q[23:16];
    eb   = group_q[15:8];
    ec   = group_q[7:0];
  end

  // Form the job and the next group state
  always_comb begin
    job_valid_o = 1'b0;
    job_o       = '0;
    group_d     = group_q;
    pos_d       = pos_q;
    remain_d    = remain_q;
    if (!decode_q) begin
      if (enc_pos == 2'd2 || item_i.in_last) begin
        job_valid_o     = accept_i;
        job_o.bytes[0]  = {2'b00, enc_grp[23:18]} + CharOffset;
        job_o.bytes[1]  = {2'b00, enc_grp[17:12]} + CharOffset;
        job_o.bytes[2]  = {2'b00, enc_grp[11:6]} + CharOffset;
        job_o.bytes[3]  = {2'b00, enc_grp[5:0]} + CharOffset;
        job_o.last_idx  = 2'd3;
        job_o.ending    = item_i.in_last;
        group_d         = '0;
        pos_d           = '0;
      end else begin
        group_d = enc_grp;
        pos_d   = enc_pos + 2'd1;
      end
    end else begin
      if (pos_q != 2'd3) begin
        group_d = dec_grp;
        pos_d   = pos_q + 2'd1;
      end else begin
        // Overlapping bits of neighboring values are ORed, not concatenated
        job_valid_o    = accept_i && (take != 2'd0);
        job_o.bytes[0] = {ea[5:0], 2'b00} | {4'h0, eb[7:4]};
        job_o.bytes[1] = {eb[3:0], 4'h0} | {2'b00, ec[7:2]};
        job_o.bytes[2] = {ec[1:0], 6'h00} | dec_val;
        job_o.bytes[3] = '0;
        job_o.last_idx = take - 2'd1;
        job_o.ending   = (remain_q == {14'd0, take}) || item_i.in_last;
        remain_d       = remain_q - {14'd0, take};
        group_d        = '0;
        pos_d          = '0;
      end
    end
    // Close the message: drop any partial group and rearm the length
    if (item_i.in_last) begin
      group_d  = '0;
      pos_d    = '0;
      remain_d = length_q;
    end
  end

  // Hold configuration and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decode_q <= 1'b0;
      length_q <= '0;
      remain_q <= '0;
      group_q  <= '0;
      pos_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegDecodeMode: begin
          decode_q <= cfg_data_i[0];
          group_q  <= '0;
          pos_q    <= '0;
        end
        RegMessageLength: begin
          length_q <= cfg_data_i;
          remain_q <= cfg_data_i;
        end
        default: ;
      endcase
    end else if (accept_i) begin
      group_q  <= group_d;
      pos_q    <= pos_d;
      remain_q <= remain_d;
    end
  end

`ifndef SYNTHESIS
  // Encoding never leaves a full group waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !decode_q |-> pos_q != 2'd3)
    else $error("encoder holds four gathered bytes");

  // A decode job never carries more bytes than remain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_o && decode_q) |-> ({14'd0, job_o.last_idx} < remain_q))
    else $error("decode job exceeds remaining length");
`endif

endmodule

// ----- src/tpc_fifo.sv -----
// Short job queue between the front and back parts of the codec.
// Depends on tpc_pkg for the job type.
module tpc_fifo #(
  parameter int unsigned Depth = tpc_pkg::JobDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tpc_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output tpc_pkg::job_t data_o
);
  import tpc_pkg::*;

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

  job_t                mem_q [Depth];
  logic [PtrWidth-1:0] wr_q, rd_q;
  logic [CntWidth-1:0] cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // No job is offered while the queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  // Fill count follows the transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("fill count lost a push");
`endif

endmodule

// ----- src/tpc_back.sv -----
// Back part of the codec: walks the head job one byte per transfer and
// presents it as the result item. Depends on tpc_pkg.
module tpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  input  tpc_pkg::job_t      job_i,
  output logic               job_pop_o,
  input  logic               pop_i,
  output tpc_pkg::out_item_t item_o
);
  import tpc_pkg::*;

  logic [1:0] idx_q;
  logic       at_last;
  logic       xfer;

  assign at_last   = (idx_q == job_i.last_idx);
  assign xfer      = pop_i && !job_empty_i;
  assign job_pop_o = xfer && at_last;

  // Present the current byte of the head job
  always_comb begin
    item_o.out_byte    = job_i.bytes[idx_q];
    item_o.run_last    = at_last;
    item_o.message_end = at_last && job_i.ending;
  end

  // Advance within the job, rewind when it retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
    end
  end

`ifndef SYNTHESIS
  // The byte index stays inside the head job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_empty_i |-> idx_q <= job_i.last_idx)
    else $error("byte index beyond head job");

  // A new job always starts at its first byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> idx_q == 2'd0)
    else $error("byte index not rewound");
`endif

endmodule

// ----- src/three_to_four_printable_codec_unit.sv -----
// Top level of the three-to-four printable codec: front, job queue, back.
// Depends on tpc_pkg, tpc_front, tpc_fifo and tpc_back.
//
// Encode mode takes bytes and returns four printable characters (6-bit
// slice plus 33) per group of three bytes, a short final group padded with
// zeros; decode mode takes characters and returns three bytes per group of
// four, stopping after message_length bytes and dropping a trailing partial
// group. Input items are taken on push transfers while the job queue is not
// full, and results leave on pop transfers through the single result port;
// decoding takes one character per cycle while the result side keeps
// popping. The finished group travels through a two-entry job queue, so
// input keeps flowing while the result side stalls, until both entries
// wait. A completed group's job is registered in the queue and read from
// its head. Write configuration only while no message is in flight.
module three_to_four_printable_codec_unit #(
  parameter int unsigned QueueDepth = tpc_pkg::JobDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tpc_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [tpc_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             push,
  output logic                             full,
  input  tpc_pkg::in_item_t                in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output tpc_pkg::out_item_t               out_item_o
);
  import tpc_pkg::*;

  logic accept;
  logic job_valid;
  job_t job_in, job_head;
  logic job_empty, job_pop;

  // Take an item on each push transfer
  assign accept = push && !full;
  assign empty  = job_empty;

  tpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  tpc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .data_o  (job_head)
  );

  tpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .pop_i       (pop),
    .item_o      (out_item_o)
  );

`ifndef SYNTHESIS
  // Message end only marks the last result of a group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.message_end) |-> out_item_o.run_last)
    else $error("message end without run last");
`endif

endmodule
